### rtl/mmrq_pkg.sv
package mmrq_pkg;

    // Mailboxes that have an owner register; higher-numbered mailboxes never match.
    localparam int CFG_OWNERS = 3;
    localparam int OWN_IDX_W  = 2;

    localparam int DEF_NUM_BOXES   = 3;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int ID_W    = 8;
    localparam int MSG_W   = 32;
    localparam int EN_W    = 3;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_OWNER_0 = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_OWNER_1 = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_OWNER_2 = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE  = 2'd3;

    localparam logic ACT_SEND = 1'b0;
    localparam logic ACT_RECV = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOBOX = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic                 hit;
        logic [OWN_IDX_W-1:0] box;
    } lookup_t;

endpackage

### rtl/mmrq_ram.sv
module mmrq_ram
    #(
        parameter int WIDTH = 32,
        parameter int DEPTH = 48
    )
    (
        input  logic                     clk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic                     re,
        input  logic [$clog2(DEPTH)-1:0] raddr,
        output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/mmrq_cfg.sv
module mmrq_cfg
    import mmrq_pkg::*;
    #(
        parameter int NUM_BOXES = DEF_NUM_BOXES
    )
    (
        input  logic               clk,
        input  logic               rst_n,
        input  logic               psel,
        input  logic               penable,
        input  logic               pwrite,
        input  logic [PADDR_W-1:0] paddr,
        input  logic [PDATA_W-1:0] pwdata,
        output logic [PDATA_W-1:0] prdata,
        input  logic [ID_W-1:0]    proc_id,
        output lookup_t            lookup
    );

    logic [ID_W-1:0]      owner_reg [CFG_OWNERS];
    logic [ID_W-1:0]      owner_next [CFG_OWNERS];
    logic [EN_W-1:0]      enable_reg;
    logic [EN_W-1:0]      enable_next;
    logic                 wr_fire;
    logic [REG_IDX_W-1:0] reg_idx;

    assign wr_fire = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_comb
    begin
        for (int i = 0; i < CFG_OWNERS; i++)
        begin
            owner_next[i] = owner_reg[i];
        end
        enable_next = enable_reg;
        if (wr_fire)
        begin
            case (reg_idx)
                REG_OWNER_0: owner_next[0] = pwdata[ID_W-1:0];
                REG_OWNER_1: owner_next[1] = pwdata[ID_W-1:0];
                REG_OWNER_2: owner_next[2] = pwdata[ID_W-1:0];
                REG_ENABLE:  enable_next   = pwdata[EN_W-1:0];
                default:     enable_next   = enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_OWNERS; i++)
            begin
                owner_reg[i] <= '0;
            end
            enable_reg <= '0;
        end
        else
        begin
            owner_reg  <= owner_next;
            enable_reg <= enable_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_OWNER_0: prdata = PDATA_W'(owner_reg[0]);
            REG_OWNER_1: prdata = PDATA_W'(owner_reg[1]);
            REG_OWNER_2: prdata = PDATA_W'(owner_reg[2]);
            REG_ENABLE:  prdata = PDATA_W'(enable_reg);
            default:     prdata = '0;
        endcase
    end

    // Compare against all owners at once; the highest-numbered match wins.
    always_comb
    begin
        lookup.hit = 1'b0;
        lookup.box = '0;
        for (int i = 0; i < CFG_OWNERS; i++)
        begin
            if (i < NUM_BOXES && enable_reg[i] && owner_reg[i] == proc_id)
            begin
                lookup.hit = 1'b1;
                lookup.box = OWN_IDX_W'(i);
            end
        end
    end

endmodule

### rtl/multi_mailbox_ring_queue_core.sv
// Mailbox queues, one circular queue of 32-bit words per mailbox.
// Input channel (in_valid/in_ready): action, proc_id, message. A send beat
// appends message to the mailbox owned by proc_id; a receive beat pops the
// oldest word from the caller's mailbox. Each input beat yields exactly one
// result beat on the output channel (out_valid/out_ready): status and
// message_out (the popped word on a successful receive, zero otherwise).
// Owner ids and enable bits are written over the APB port at 0x0, 0x4,
// 0x8 (owner ids) and 0xC (enable bits); write them only while idle.
// A queue holds at most QUEUE_DEPTH-1 words; a send to a full queue is
// refused with a full status and nothing is overwritten.
// The RAM read is issued at the accepting edge, together with the read-stage
// registers; the output register loads from them once the output is free.
// Throughput: one item per cycle while the output is taken. A result that
// waits in the output register still lets one more item in; after that,
// in_ready drops until out_ready frees the output.
// Reset clears all pointers (every queue empty), owner ids and enables;
// the message RAM is not cleared and needs no clearing pass.
module multi_mailbox_ring_queue_core
    import mmrq_pkg::*;
    #(
        parameter int NUM_BOXES   = DEF_NUM_BOXES,
        parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
    )
    (
        input  logic               clk,
        input  logic               rst_n,
        input  logic               psel,
        input  logic               penable,
        input  logic               pwrite,
        input  logic [PADDR_W-1:0] paddr,
        input  logic [PDATA_W-1:0] pwdata,
        output logic [PDATA_W-1:0] prdata,
        output logic               pready,
        input  logic               in_valid,
        output logic               in_ready,
        input  logic               action,
        input  logic [ID_W-1:0]    proc_id,
        input  logic [MSG_W-1:0]   message,
        output logic               out_valid,
        input  logic               out_ready,
        output logic [1:0]         status,
        output logic [MSG_W-1:0]   message_out
    );

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int BOX_W   = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
    localparam int RAM_D   = NUM_BOXES * QUEUE_DEPTH;
    localparam int RAM_A_W = $clog2(RAM_D);

    lookup_t              lk;
    logic [BOX_W-1:0]     box_idx;
    logic [PTR_W-1:0]     wr_ptr_reg  [NUM_BOXES];
    logic [PTR_W-1:0]     wr_ptr_next [NUM_BOXES];
    logic [PTR_W-1:0]     rd_ptr_reg  [NUM_BOXES];
    logic [PTR_W-1:0]     rd_ptr_next [NUM_BOXES];
    logic [PTR_W-1:0]     wp;
    logic [PTR_W-1:0]     rp;
    logic [PTR_W-1:0]     wp_adv;
    logic [PTR_W-1:0]     rp_adv;
    logic [PTR_W-1:0]     ptr_sel;
    logic [RAM_A_W-1:0]   ram_addr;
    logic                 ram_we;
    logic                 ram_re;
    logic [MSG_W-1:0]     ram_rdata;
    logic                 in_fire;
    logic                 is_recv;
    logic                 q_full;
    logic                 q_empty;
    status_t              st_new;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    status_t              s1_status_reg;
    logic                 s1_rd_reg;
    logic                 s1_move;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    status_t              status_reg;
    logic [MSG_W-1:0]     message_out_reg;

    mmrq_cfg #(
        .NUM_BOXES (NUM_BOXES)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .proc_id (proc_id),
        .lookup  (lk)
    );

    assign pready = 1'b1;

    assign box_idx = BOX_W'(lk.box);
    assign wp      = wr_ptr_reg[box_idx];
    assign rp      = rd_ptr_reg[box_idx];
    assign wp_adv  = (wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
    assign rp_adv  = (rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
    assign q_full  = (wp_adv == rp);
    assign q_empty = (rp == wp);
    assign is_recv = (action == ACT_RECV);

    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_fire  = in_valid && in_ready;

    assign ptr_sel  = is_recv ? rp : wp;
    assign ram_addr = RAM_A_W'(box_idx) * RAM_A_W'(QUEUE_DEPTH) + RAM_A_W'(ptr_sel);
    assign ram_we   = in_fire && lk.hit && !is_recv && !q_full;
    assign ram_re   = in_fire && lk.hit && is_recv && !q_empty;

    mmrq_ram #(
        .WIDTH (MSG_W),
        .DEPTH (RAM_D)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (message),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (!lk.hit)
        begin
            st_new = ST_NOBOX;
        end
        else if (is_recv)
        begin
            st_new = q_empty ? ST_EMPTY : ST_OK;
        end
        else
        begin
            st_new = q_full ? ST_FULL : ST_OK;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (ram_we)
        begin
            wr_ptr_next[box_idx] = wp_adv;
        end
        if (ram_re)
        begin
            rd_ptr_next[box_idx] = rp_adv;
        end
    end

    always_comb
    begin
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BOXES; i++)
            begin
                wr_ptr_reg[i] <= '0;
                rd_ptr_reg[i] <= '0;
            end
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The RAM read data is registered; pick it up on the way out.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_status_reg <= st_new;
            s1_rd_reg     <= ram_re;
        end
        if (s1_move)
        begin
            status_reg      <= s1_status_reg;
            message_out_reg <= s1_rd_reg ? ram_rdata : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign message_out = message_out_reg;

    a_msg_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg == ST_OK || message_out_reg == '0))
        else $error("nonzero message_out with a failing status");

    a_recv_reads_ram: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> (s1_valid_reg && s1_rd_reg && s1_status_reg == ST_OK))
        else $error("successful receive did not reach the read stage");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> (s1_valid_reg && $stable(s1_status_reg)
            && $stable(s1_rd_reg)))
        else $error("stalled beat in the read stage changed");

    a_no_write_on_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && st_new != ST_OK) |-> (!ram_we && !ram_re))
        else $error("refused item touched the message store");

endmodule

### dv/testbench.sv
module testbench;
    import mmrq_pkg::*;

    localparam int BOXES = DEF_NUM_BOXES;
    localparam int DEPTH = DEF_QUEUE_DEPTH;

    typedef struct packed {
        logic             act;
        logic [ID_W-1:0]  id;
        logic [MSG_W-1:0] msg;
    } mbox_request_t;

    typedef struct packed {
        status_t          status;
        logic [MSG_W-1:0] data;
    } mbox_reply_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic               action;
    logic [ID_W-1:0]    proc_id;
    logic [MSG_W-1:0]   message;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic [MSG_W-1:0]   message_out;

    // mailbox shadow state
    logic [MSG_W-1:0] box_words [BOXES][DEPTH];
    int               wr_ptr [BOXES];
    int               rd_ptr [BOXES];
    logic [ID_W-1:0]  owner_ids [CFG_OWNERS];
    logic [EN_W-1:0]  owner_en;

    mbox_request_t request_queue [$];
    mbox_reply_t   reply_queue [$];
    mbox_reply_t   head_reply;
    logic          in_fire;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            error_count;

    multi_mailbox_ring_queue_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .proc_id     (proc_id),
        .message     (message),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .message_out (message_out)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Highest-numbered enabled owner wins; a full queue keeps one slot free.
    function automatic mbox_reply_t predict_reply(logic act, logic [ID_W-1:0] id,
                                                  logic [MSG_W-1:0] msg);
        mbox_reply_t r;
        int          box;
        int          nxt;
        box    = -1;
        r.data = '0;
        for (int i = 0; i < CFG_OWNERS && i < BOXES; i++)
        begin
            if (owner_en[i] && owner_ids[i] == id)
                box = i;
        end
        if (box < 0)
            r.status = ST_NOBOX;
        else if (act == ACT_SEND)
        begin
            nxt = (wr_ptr[box] + 1) % DEPTH;
            if (nxt == rd_ptr[box])
                r.status = ST_FULL;
            else
            begin
                box_words[box][wr_ptr[box]] = msg;
                wr_ptr[box] = nxt;
                r.status = ST_OK;
            end
        end
        else if (rd_ptr[box] == wr_ptr[box])
            r.status = ST_EMPTY;
        else
        begin
            r.data = box_words[box][rd_ptr[box]];
            rd_ptr[box] = (rd_ptr[box] + 1) % DEPTH;
            r.status = ST_OK;
        end
        return r;
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_fire)
        begin
            // hold the beat until taken
        end
        else if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
        begin
            in_valid <= 1'b1;
            action   <= request_queue[0].act;
            proc_id  <= request_queue[0].id;
            message  <= request_queue[0].msg;
            void'(request_queue.pop_front());
        end
        else
            in_valid <= 1'b0;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor: check replies, then predict newly accepted requests
    always @(posedge clk)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (reply_queue.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected reply: status %0d message_out %h",
                                 status, message_out);
                end
                else
                begin
                    head_reply = reply_queue.pop_front();
                    if (status !== head_reply.status || message_out !== head_reply.data)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("reply mismatch: expected status %0d data %h, got %0d %h",
                                     head_reply.status, head_reply.data, status, message_out);
                    end
                end
            end
            if (in_valid && in_ready)
                reply_queue.push_back(predict_reply(action, proc_id, message));
        end
    end

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_OWNER_0: owner_ids[0] = val[ID_W-1:0];
            REG_OWNER_1: owner_ids[1] = val[ID_W-1:0];
            REG_OWNER_2: owner_ids[2] = val[ID_W-1:0];
            REG_ENABLE:  owner_en     = val[EN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_owners(logic [ID_W-1:0] id0, logic [ID_W-1:0] id1,
                              logic [ID_W-1:0] id2, logic [EN_W-1:0] en);
        apb_write(REG_OWNER_0, PDATA_W'(id0));
        apb_write(REG_OWNER_1, PDATA_W'(id1));
        apb_write(REG_OWNER_2, PDATA_W'(id2));
        apb_write(REG_ENABLE, PDATA_W'(en));
    endtask

    task automatic push_request(logic act, logic [ID_W-1:0] id, logic [MSG_W-1:0] msg);
        mbox_request_t req;
        req.act = act;
        req.id  = id;
        req.msg = msg;
        request_queue.push_back(req);
    endtask

    // Mostly ids of configured owners, with send/receive bias shifting so
    // queues swing between empty and full.
    task automatic queue_traffic(int count);
        int              send_pct;
        logic            act;
        logic [ID_W-1:0] id;
        send_pct = 50;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       send_pct = 15;
                    1:       send_pct = 50;
                    default: send_pct = 85;
                endcase
            end
            act = ($urandom_range(0, 99) < send_pct) ? ACT_SEND : ACT_RECV;
            if ($urandom_range(0, 99) < 85)
                id = owner_ids[$urandom_range(0, CFG_OWNERS - 1)];
            else
                id = ID_W'($urandom_range(0, 255));
            push_request(act, id, $urandom());
        end
    endtask

    // pause the sender until every reply is back
    task automatic drain_replies();
        do @(negedge clk);
        while (request_queue.size() != 0 || in_valid || reply_queue.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int guard;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        action        = ACT_SEND;
        proc_id       = '0;
        message       = '0;
        out_ready     = 1'b0;
        in_fire       = 1'b0;
        error_count   = 0;
        send_idle_pct = 34;
        recv_idle_pct = 72;
        owner_en      = '0;
        for (int b = 0; b < BOXES; b++)
        begin
            wr_ptr[b] = 0;
            rd_ptr[b] = 0;
        end
        for (int i = 0; i < CFG_OWNERS; i++)
            owner_ids[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_owners(8'h00, 8'hFF, 8'h5A, 3'b111);
        push_request(ACT_RECV, 8'h00, 32'h0);          // empty queue
        push_request(ACT_SEND, 8'h11, $urandom());     // no owner
        push_request(ACT_RECV, 8'hEE, $urandom());
        push_request(ACT_SEND, 8'hFF, 32'h0000_0000);
        push_request(ACT_SEND, 8'hFF, 32'hFFFF_FFFF);
        for (int n = 0; n < DEPTH - 3; n++)
            push_request(ACT_SEND, 8'hFF, $urandom());
        push_request(ACT_SEND, 8'hFF, 32'hDEAD_BEEF);  // queue full, refused
        push_request(ACT_RECV, 8'hFF, $urandom());
        push_request(ACT_RECV, 8'hFF, 32'h0);
        push_request(ACT_SEND, 8'h5A, 32'h5A5A_5A5A);
        push_request(ACT_RECV, 8'h5A, 32'h0);
        push_request(ACT_RECV, 8'h5A, 32'h0);
        push_request(ACT_SEND, 8'h00, 32'h0000_0001);
        drain_replies();

        // duplicate owner: mailbox two shadows mailbox zero
        set_owners(8'h33, 8'hCC, 8'h33, 3'b111);
        queue_traffic(170);
        drain_replies();
        set_owners(8'hFF, 8'hFF, 8'h00, 3'b011);
        queue_traffic(170);
        drain_replies();

        send_idle_pct = 72;
        recv_idle_pct = 34;
        set_owners(ID_W'($urandom()), ID_W'($urandom()), ID_W'($urandom()),
                   EN_W'($urandom()));
        queue_traffic(170);
        drain_replies();
        apb_write(REG_ENABLE, PDATA_W'(3'b000));
        queue_traffic(50);
        drain_replies();
        set_owners(8'h00, 8'h00, 8'h00, 3'b001);
        queue_traffic(170);
        drain_replies();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_owners(8'h80, 8'h01, 8'hFE, 3'b110);
        queue_traffic(170);
        drain_replies();
        queue_traffic(170);

        do @(negedge clk); while (request_queue.size() != 0 || in_valid);
        guard = 0;
        while (reply_queue.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        if (reply_queue.size() != 0)
        begin
            $display("%0d replies never arrived", reply_queue.size());
            error_count += reply_queue.size();
        end
        repeat (10) @(negedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
rtl/mmrq_pkg.sv
rtl/mmrq_ram.sv
rtl/mmrq_cfg.sv
rtl/multi_mailbox_ring_queue_core.sv
dv/testbench.sv
